/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl that checks itself
// clocked on clk, disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define DTJD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define DTJD_ASSERT_NEXT(lbl, ante, cons, msg) \
	`DTJD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/core/dtjd_pkg.sv */
// shared widths, constants and the month table for the julian day converter
// no dependencies
package dtjd_pkg;

	localparam int DaysW = 25;
	localparam int FracW = 17;
	localparam int OutW  = 40;
	localparam int MtermW = 9;

	localparam int EpochOffset = 1720995;
	localparam int JdScale     = 100000;
	localparam int GregKey     = 15 + 31 * (10 + 12 * 1582);
	// floor(ay/100) done as floor((ay + CentBias)/100) - CentBias/100
	localparam int CentBias    = 16500;
	localparam int CentRecip   = 41944;
	localparam int CentShift   = 22;
	// rounded fraction = floor((125*s + 53) / 108), reciprocal of 108
	localparam int FracRecip   = 19884108;
	localparam int FracShift   = 31;
	localparam int FracMax     = 100281;

	// floor(30.6001 * am) for the adjusted month number
	function automatic logic [MtermW-1:0] month_term(input logic [4:0] am);
		logic [MtermW-1:0] v;
		case (am)
			5'd4:    v = 9'd122;
			5'd5:    v = 9'd153;
			5'd6:    v = 9'd183;
			5'd7:    v = 9'd214;
			5'd8:    v = 9'd244;
			5'd9:    v = 9'd275;
			5'd10:   v = 9'd306;
			5'd11:   v = 9'd336;
			5'd12:   v = 9'd367;
			5'd13:   v = 9'd397;
			5'd14:   v = 9'd428;
			5'd15:   v = 9'd459;
			5'd16:   v = 9'd489;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/date_time_to_julian_day.sv */
// calendar date and time of day to julian date times 100000
// an accepted beat passes through stages s1, s2, s3, s4 and s5 before its result reaches the output
// throughput: one beat per cycle; the whole pipeline holds while the output stalls
// reset clears the stage valid bits only, data registers are not reset
`include "assert_macros.svh"
module date_time_to_julian_day (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              date_valid,
	output logic                              date_stall,
	input  logic [4:0]                        day,
	input  logic [3:0]                        month,
	input  logic signed [14:0]                year,
	input  logic [4:0]                        hour,
	input  logic [5:0]                        minute,
	input  logic [5:0]                        second_of_minute,
	output logic                              jd_valid,
	input  logic                              jd_stall,
	output logic signed [dtjd_pkg::OutW-1:0]  julian_day_scaled
);
	import dtjd_pkg::*;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [3:0] vld_bus;
	logic signed [DaysW-1:0] days_s3;
	logic [FracW-1:0] frac_s3;

	// a stalled result freezes every stage
	assign adv        = !(vld_s5 && jd_stall);
	assign date_stall = !adv;
	assign jd_valid   = vld_s5;
	assign vld_bus    = {vld_s4, vld_s3, vld_s2, vld_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= date_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	dtjd_day u_day (
		.clk   (clk),
		.en    (adv),
		.day   (day),
		.month (month),
		.year  (year),
		.hour  (hour),
		.days  (days_s3)
	);

	dtjd_tod u_tod (
		.clk              (clk),
		.en               (adv),
		.hour             (hour),
		.minute           (minute),
		.second_of_minute (second_of_minute),
		.frac             (frac_s3)
	);

	dtjd_scale u_scale (
		.clk  (clk),
		.en   (adv),
		.days (days_s3),
		.frac (frac_s3),
		.jd   (julian_day_scaled)
	);

	`DTJD_ASSERT_NEXT(a_hold_on_stall, jd_valid && jd_stall, jd_valid && $stable(vld_bus), "pipeline moved while output stalled")
	`DTJD_ASSERT_NEXT(a_last_stage_drains, vld_s4 && !date_stall, jd_valid, "beat lost between last stages")
	`DTJD_ASSERT(a_frac_range, !vld_s3 || frac_s3 <= FracW'(FracMax), "day fraction out of range")

endmodule

/* rtl/core/dtjd_day.sv */
// integer julian day number path, three register stages
// depends on dtjd_pkg
module dtjd_day (
	input  logic                               clk,
	input  logic                               en,
	input  logic [4:0]                         day,
	input  logic [3:0]                         month,
	input  logic signed [14:0]                 year,
	input  logic [4:0]                         hour,
	output logic signed [dtjd_pkg::DaysW-1:0]  days
);
	import dtjd_pkg::*;

	// stage 1: adjusted year, month term, gregorian test and before-noon flag
	logic               march;
	logic signed [15:0] y16;
	logic signed [15:0] ay;
	logic [4:0]         am;
	logic signed [24:0] y25;
	logic signed [24:0] my;
	logic signed [24:0] gkey;

	logic signed [15:0] ay_s1;
	logic [MtermW-1:0]  mterm_s1;
	logic [4:0]         day_s1;
	logic               greg_s1;
	logic               dec_s1;

	always_comb begin
		march = month > 4'd2;
		y16   = 16'(year);
		ay    = march ? y16 : y16 - 16'sd1;
		am    = march ? 5'(month) + 5'd1 : 5'(month) + 5'd13;
		y25   = 25'(year);
		my    = y25 * 25'sd12 + signed'(25'(month));
		gkey  = my * 25'sd31 + signed'(25'(day));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s1    <= ay;
			mterm_s1 <= month_term(am);
			day_s1   <= day;
			greg_s1  <= gkey >= 25'(GregKey);
			dec_s1   <= hour < 5'd12;
		end
	end

	// stage 2: base day count and century via reciprocal multiply
	logic signed [25:0]    yday;
	logic signed [DaysW-1:0] base;
	logic signed [16:0]    ub;
	logic [31:0]           cprod;

	logic signed [DaysW-1:0] base_s2;
	logic [8:0]              acent_s2;
	logic                    greg_s2;

	always_comb begin
		yday  = 26'(ay_s1) * 26'sd1461;
		base  = DaysW'(yday >>> 2) + signed'(DaysW'(mterm_s1)) + signed'(DaysW'(day_s1))
			+ DaysW'(EpochOffset) - (dec_s1 ? DaysW'(1) : DaysW'(0));
		ub    = 17'(ay_s1) + 17'(CentBias);
		cprod = 32'(ub[15:0]) * 32'(CentRecip);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2  <= base;
			acent_s2 <= cprod[CentShift+8:CentShift];
			greg_s2  <= greg_s1;
		end
	end

	// stage 3: gregorian correction 2 - a + floor(a/4)
	logic signed [9:0] a;
	logic signed [9:0] corr;
	logic signed [DaysW-1:0] days_s3;

	always_comb begin
		a    = signed'(10'(acent_s2)) - 10'(CentBias / 100);
		corr = 10'sd2 - a + (a >>> 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= base_s2 + (greg_s2 ? DaysW'(corr) : DaysW'(0));
		end
	end

	assign days = days_s3;

endmodule

/* rtl/core/dtjd_tod.sv */
// time of day to rounded fraction of a day in units of 1e-5, three stages
// depends on dtjd_pkg
module dtjd_tod (
	input  logic                           clk,
	input  logic                           en,
	input  logic [4:0]                     hour,
	input  logic [5:0]                     minute,
	input  logic [5:0]                     second_of_minute,
	output logic [dtjd_pkg::FracW-1:0]     frac
);
	import dtjd_pkg::*;

	// stage 1: seconds past noon
	logic [16:0] hs;
	logic [16:0] secs;
	logic [16:0] secs_s1;

	always_comb begin
		hs   = 17'(hour) * 17'd3600;
		secs = (hour < 5'd12 ? hs + 17'd43200 : hs - 17'd43200)
			+ 17'(minute) * 17'd60 + 17'(second_of_minute);
	end

	always_ff @(posedge clk) begin
		if (en) secs_s1 <= secs;
	end

	// stage 2: 125*s plus the rounding bias, ties go down
	logic [23:0] x_s2;

	always_ff @(posedge clk) begin
		if (en) x_s2 <= 24'(secs_s1) * 24'd125 + 24'd53;
	end

	// stage 3: divide by 108 through the reciprocal
	logic [48:0]      prod;
	logic [FracW-1:0] frac_s3;

	assign prod = 49'(x_s2) * 49'(FracRecip);

	always_ff @(posedge clk) begin
		if (en) frac_s3 <= prod[FracShift+FracW-1:FracShift];
	end

	assign frac = frac_s3;

endmodule

/* rtl/core/dtjd_scale.sv */
// scales the day number by 100000 and adds the day fraction, two stages
// depends on dtjd_pkg
module dtjd_scale (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [dtjd_pkg::DaysW-1:0] days,
	input  logic [dtjd_pkg::FracW-1:0]        frac,
	output logic signed [dtjd_pkg::OutW-1:0]  jd
);
	import dtjd_pkg::*;

	logic signed [41:0]     dprod;
	logic signed [OutW-1:0] dprod_s4;
	logic [FracW-1:0]       frac_s4;
	logic signed [OutW-1:0] jd_s5;

	assign dprod = 42'(days) * 42'(JdScale);

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s4 <= dprod[OutW-1:0];
			frac_s4  <= frac;
			// result wraps modulo 2^40
			jd_s5    <= dprod_s4 + signed'(OutW'(frac_s4));
		end
	end

	assign jd = jd_s5;

endmodule

/* tb/date_time_to_julian_day_test.sv */
// self-checking bench for the calendar date to scaled julian date converter
// drives a directed table then random beats, checks every result in order
// depends on dtjd_pkg and the date_time_to_julian_day top level
`timescale 1ns / 1ps

module date_time_to_julian_day_test;
	import dtjd_pkg::*;

	localparam int RandomBeats  = 1930;
	localparam int CalmBeats    = 250;
	localparam int IdleLimit    = 1000;
	localparam int DrainCycles  = 20;
	localparam int DirectedRows = 21;

	localparam longint EpochDays  = 1720995;
	localparam longint Scale      = 100000;
	localparam longint SwitchKey  = 15 + 31 * (10 + 12 * 1582);
	localparam longint HalfDaySec = 43200;

	typedef struct packed {
		logic [4:0]        day;
		logic [3:0]        month;
		logic [14:0]       year;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second_of_minute;
		logic              has_jd;
		logic [OutW-1:0]   jd;
	} date_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic date_valid;
	logic date_stall;
	logic [4:0] day;
	logic [3:0] month;
	logic signed [14:0] year;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second_of_minute;
	logic jd_valid;
	logic jd_stall;
	logic signed [OutW-1:0] julian_day_scaled;

	// typed-in value that rides along with the beat on the input side
	logic has_typed_jd;
	logic [OutW-1:0] typed_jd;

	logic [OutW-1:0] pending_jd[$];
	int error_count = 0;
	int idle_cycles = 0;
	logic calm_tail;

	// extremes, the gregorian switch, tie rounding and raw out-of-range fields
	date_row_t directed_rows [0:DirectedRows-1] = '{
		'{5'd1,  4'd1,  -15'sd4712, 5'd12, 6'd0,  6'd0,  1'b1, 40'sd0},
		'{5'd1,  4'd1,  -15'sd4712, 5'd0,  6'd0,  6'd0,  1'b1, -40'sd50000},
		'{5'd1,  4'd1,  15'sd2000,  5'd12, 6'd0,  6'd0,  1'b1, 40'sd245154500000},
		'{5'd1,  4'd1,  15'sd2000,  5'd0,  6'd0,  6'd0,  1'b1, 40'sd245154450000},
		'{5'd15, 4'd10, 15'sd1582,  5'd0,  6'd0,  6'd0,  1'b1, 40'sd229916050000},
		'{5'd4,  4'd10, 15'sd1582,  5'd0,  6'd0,  6'd0,  1'b1, 40'sd229915950000},
		'{5'd5,  4'd10, 15'sd1582,  5'd12, 6'd0,  6'd0,  1'b0, 40'd0},
		'{5'd14, 4'd10, 15'sd1582,  5'd23, 6'd59, 6'd59, 1'b0, 40'd0},
		'{5'd31, 4'd12, 15'sd9999,  5'd23, 6'd59, 6'd59, 1'b0, 40'd0},
		'{5'd28, 4'd2,  15'sd1900,  5'd6,  6'd30, 6'd15, 1'b0, 40'd0},
		'{5'd29, 4'd2,  15'sd2000,  5'd18, 6'd0,  6'd0,  1'b0, 40'd0},
		'{5'd1,  4'd3,  -15'sd1,    5'd12, 6'd0,  6'd0,  1'b0, 40'd0},
		'{5'd1,  4'd1,  15'sd0,     5'd12, 6'd0,  6'd54, 1'b0, 40'd0},
		'{5'd1,  4'd1,  15'sd2000,  5'd12, 6'd0,  6'd55, 1'b0, 40'd0},
		'{5'd0,  4'd0,  15'sd2000,  5'd12, 6'd0,  6'd0,  1'b0, 40'd0},
		'{5'd31, 4'd15, 15'sd2000,  5'd31, 6'd63, 6'd63, 1'b0, 40'd0},
		'{5'd31, 4'd13, -15'sd16384, 5'd11, 6'd59, 6'd59, 1'b0, 40'd0},
		'{5'd31, 4'd12, 15'sd16383, 5'd23, 6'd59, 6'd59, 1'b0, 40'd0},
		'{5'd1,  4'd1,  15'sd2000,  5'd11, 6'd59, 6'd59, 1'b0, 40'd0},
		'{5'd1,  4'd1,  15'sd2000,  5'd12, 6'd59, 6'd59, 1'b0, 40'd0},
		'{5'd15, 4'd14, -15'sd5000, 5'd31, 6'd0,  6'd0,  1'b0, 40'd0}
	};

	date_time_to_julian_day u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.date_valid        (date_valid),
		.date_stall        (date_stall),
		.day               (day),
		.month             (month),
		.year              (year),
		.hour              (hour),
		.minute            (minute),
		.second_of_minute  (second_of_minute),
		.jd_valid          (jd_valid),
		.jd_stall          (jd_stall),
		.julian_day_scaled (julian_day_scaled)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_quot(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic [OutW-1:0] scaled_julian_date(logic [4:0] d, logic [3:0] m,
			logic signed [14:0] y, logic [4:0] h, logic [5:0] mi, logic [5:0] s);
		longint dd, mm, yy, adj_year, adj_month, days, secs, frac, rem, cent, total;
		dd = d;
		mm = m;
		yy = y;
		// january and february belong to the previous year
		if (mm > 2) begin
			adj_year = yy;
			adj_month = mm + 1;
		end else begin
			adj_year = yy - 1;
			adj_month = mm + 13;
		end
		days = floor_quot(1461 * adj_year, 4) + floor_quot(306001 * adj_month, 10000)
			+ dd + EpochDays;
		if (dd + 31 * (mm + 12 * yy) >= SwitchKey) begin
			cent = floor_quot(adj_year, 100);
			days = days + 2 - cent + floor_quot(cent, 4);
		end
		// the julian day starts at noon
		secs = longint'(h) * 3600 - HalfDaySec;
		if (secs < 0) begin
			secs = secs + 2 * HalfDaySec;
			days = days - 1;
		end
		secs = secs + longint'(mi) * 60 + longint'(s);
		frac = (secs * 125) / 108;
		rem = (secs * 125) % 108;
		if (2 * rem > 108)
			frac = frac + 1;
		total = days * Scale + frac;
		return total[OutW-1:0];
	endfunction

	task automatic random_date(output date_row_t r);
		int pick;
		pick = $urandom_range(99);
		r = '0;
		if (pick < 12) begin
			r.day = 5'($urandom);
			r.month = 4'($urandom);
			r.year = 15'($urandom);
			r.hour = 5'($urandom);
			r.minute = 6'($urandom);
			r.second_of_minute = 6'($urandom);
		end else begin
			r.day = 5'($urandom_range(31, 1));
			r.month = 4'($urandom_range(12, 1));
			r.year = 15'($urandom_range(14711) - 4712);
			r.hour = 5'($urandom_range(23));
			r.minute = 6'($urandom_range(59));
			r.second_of_minute = 6'($urandom_range(59));
			// crowd some beats around the gregorian switch
			if (pick < 30) begin
				r.year = 15'sd1582;
				r.month = 4'($urandom_range(11, 9));
			end
		end
	endtask

	// expectations go in on accepted input beats, results come out in order
	always @(posedge clk) begin
		logic [OutW-1:0] want;
		if (jd_valid && !jd_stall) begin
			if (pending_jd.size() == 0) begin
				$display("%0t: unexpected result julian_day_scaled got %0d",
					$time, julian_day_scaled);
				error_count++;
			end else begin
				want = pending_jd.pop_front();
				if (julian_day_scaled !== want) begin
					$display("%0t: julian_day_scaled expected %0d got %0d",
						$time, $signed(want), julian_day_scaled);
					error_count++;
				end
			end
		end
		if (date_valid && !date_stall) begin
			if (has_typed_jd)
				pending_jd.push_back(typed_jd);
			else
				pending_jd.push_back(scaled_julian_date(day, month, year, hour,
					minute, second_of_minute));
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((date_valid && !date_stall) || (jd_valid && !jd_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// output side back-pressure in random bursts
	initial begin
		jd_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(40, 1)) @(posedge clk);
			if (!calm_tail && $urandom_range(2) == 0) begin
				jd_stall <= 1'b1;
				repeat ($urandom_range(17, 1)) @(posedge clk);
				jd_stall <= 1'b0;
			end
		end
	end

	initial begin
		date_row_t row;
		int total_beats;
		arst_n <= 1'b0;
		date_valid <= 1'b0;
		day <= '0;
		month <= '0;
		year <= '0;
		hour <= '0;
		minute <= '0;
		second_of_minute <= '0;
		has_typed_jd <= 1'b0;
		typed_jd <= '0;
		calm_tail <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total_beats = DirectedRows + RandomBeats;
		for (int n = 0; n < total_beats; n++) begin
			if (n < DirectedRows)
				row = directed_rows[n];
			else
				random_date(row);
			calm_tail <= (n >= total_beats - CalmBeats);
			day <= row.day;
			month <= row.month;
			year <= row.year;
			hour <= row.hour;
			minute <= row.minute;
			second_of_minute <= row.second_of_minute;
			has_typed_jd <= row.has_jd;
			typed_jd <= row.jd;
			date_valid <= 1'b1;
			do @(posedge clk); while (!(date_valid && !date_stall));
			// sender gap after the beat went through
			if (n < total_beats - CalmBeats && $urandom_range(3) == 0) begin
				date_valid <= 1'b0;
				repeat ($urandom_range(17, 1)) @(posedge clk);
			end
		end
		date_valid <= 1'b0;

		while (pending_jd.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0 && pending_jd.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
